/* hdl/rbcw_pkg.sv */
// Shared types, register codes, constants and arithmetic helpers for the
// cylinder warp block. Used by every module under hdl; depends on nothing.
package rbcw_pkg;

    // request payloads
    typedef struct packed {
        logic signed [31:0] affine_x;
        logic signed [31:0] affine_y;
        logic signed [31:0] accum_x;
        logic signed [31:0] accum_y;
        logic signed [31:0] accum_z;
        logic        [15:0] random_angle;
        logic        [15:0] random_refill;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [15:0] color;
    } out_t;

    // configuration register file
    typedef struct packed {
        logic signed [31:0] offset;
        logic signed [19:0] angle;
        logic signed [31:0] scale;
        logic signed [31:0] x_gain;
        logic signed [31:0] y_gain;
        logic signed [31:0] blur;
        logic signed [31:0] amount;
    } cfg_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_X_GAIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_GAIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUR   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_AMOUNT = 3'd6;

    // multiplier and divider widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_N  = 34;
    localparam int DIV_D  = 32;

    // fixed-point constants
    localparam logic signed [MUL_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
    localparam logic signed [MUL_W-1:0] TURN_PER_RAD = 34'sd683565276;
    localparam logic        [30:0]      ONE_Q30      = 31'h4000_0000;
    localparam logic signed [31:0]      INV_RESET    = 32'sh0002_0000;
    localparam logic signed [31:0]      Q16_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]      Q16_MIN      = 32'sh8000_0000;
    localparam logic        [15:0]      DRAW_RESET   = 16'h8000;

    // rounded-up reciprocals of the series divisors, sine terms (first five)
    // then cosine terms (last six); exact floor for 32-bit dividends
    function automatic logic signed [MUL_W-1:0] series_recip(input logic [3:0] idx);
        logic signed [MUL_W-1:0] m;
        unique case (idx)
            4'd0:    m = 34'sd4997780127;
            4'd1:    m = 34'sd7635497416;
            4'd2:    m = 34'sd6544712071;
            4'd3:    m = 34'sd6871947674;
            4'd4:    m = 34'sd5726623062;
            4'd5:    m = 34'sd8329633544;
            4'd6:    m = 34'sd6108397933;
            4'd7:    m = 34'sd4908534053;
            4'd8:    m = 34'sd4581298450;
            4'd9:    m = 34'sd5726623062;
            4'd10:   m = 34'sd4294967296;
            default: m = 34'sd0;
        endcase
        return m;
    endfunction

    // right shift that goes with each reciprocal
    function automatic logic [5:0] series_shift(input logic [3:0] idx);
        logic [5:0] s;
        unique case (idx)
            4'd0:    s = 6'd39;
            4'd1:    s = 6'd39;
            4'd2:    s = 6'd38;
            4'd3:    s = 6'd37;
            4'd4:    s = 6'd35;
            4'd5:    s = 6'd40;
            4'd6:    s = 6'd39;
            4'd7:    s = 6'd38;
            4'd8:    s = 6'd37;
            4'd9:    s = 6'd36;
            4'd10:   s = 6'd33;
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // saturate to the Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = Q16_MAX;
        else if (v < -68'sd2147483648)
            r = Q16_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // round half up, then drop 30 or 16 fraction bits
    function automatic logic signed [PROD_W-1:0] rshr30(input logic signed [PROD_W-1:0] v);
        return (v + 68'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [PROD_W-1:0] rshr16(input logic signed [PROD_W-1:0] v);
        return (v + 68'sd32768) >>> 16;
    endfunction

endpackage

/* hdl/random_blur_cylinder_warp.sv */
// Cylinder warp with blurred jitter in Q16.16: one result per request.
// A request is accepted only while the block is idle; the next request can
// be accepted once the result has moved into the output register. The first
// request after a write of scale also waits, when scale is nonzero, for the
// serial divider that forms the inverse scale. The shared multiplier serves
// four sine/cosine evaluations (eleven series terms each, every term a
// multiply, a reciprocal multiply and a subtract step) plus the point and
// color math; a result held by out_stall delays the next acceptance until
// the output register is free.
// Depends on rbcw_pkg and rbcw_core.
module random_blur_cylinder_warp #(
    parameter int DRAW_COUNT = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rbcw_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rbcw_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [rbcw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rbcw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rbcw_pkg::cfg_t cfg_reg;
    rbcw_pkg::out_t out_reg;
    logic           out_valid_reg, out_valid_next;
    logic           busy, res_valid, res_take, scale_wr;
    rbcw_pkg::out_t res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset <= 32'sd0;
            cfg_reg.angle  <= 20'sd0;
            cfg_reg.scale  <= 32'sd32768;
            cfg_reg.x_gain <= 32'sd8192;
            cfg_reg.y_gain <= 32'sd8192;
            cfg_reg.blur   <= 32'sd65536;
            cfg_reg.amount <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rbcw_pkg::REG_OFFSET: cfg_reg.offset <= cfg_data;
                rbcw_pkg::REG_ANGLE:  cfg_reg.angle  <= cfg_data[19:0];
                rbcw_pkg::REG_SCALE:  cfg_reg.scale  <= cfg_data;
                rbcw_pkg::REG_X_GAIN: cfg_reg.x_gain <= cfg_data;
                rbcw_pkg::REG_Y_GAIN: cfg_reg.y_gain <= cfg_data;
                rbcw_pkg::REG_BLUR:   cfg_reg.blur   <= cfg_data;
                rbcw_pkg::REG_AMOUNT: cfg_reg.amount <= cfg_data;
                default:              cfg_reg        <= cfg_reg;
            endcase
        end
    end

    assign scale_wr = cfg_we && (cfg_addr == rbcw_pkg::REG_SCALE);

    rbcw_core #(
        .DRAW_COUNT (DRAW_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !busy),
        .item      (in_data),
        .cfg       (cfg_reg),
        .scale_wr  (scale_wr),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register
    assign res_take       = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign in_stall  = busy;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/rbcw_mul.sv */
// Shared signed multiplier with a registered product.
// Uses rbcw_pkg for operand widths.
module rbcw_mul (
    input  logic                               clk,
    input  logic signed [rbcw_pkg::MUL_W-1:0]  a,
    input  logic signed [rbcw_pkg::MUL_W-1:0]  b,
    output logic signed [rbcw_pkg::PROD_W-1:0] p
);

    logic signed [rbcw_pkg::PROD_W-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= rbcw_pkg::PROD_W'(a) * rbcw_pkg::PROD_W'(b);
    end

    assign p = p_reg;

endmodule

/* hdl/rbcw_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses rbcw_pkg for dividend and divisor widths.
module rbcw_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rbcw_pkg::DIV_N-1:0]     dividend,
    input  logic [rbcw_pkg::DIV_D-1:0]     divisor,
    output logic                           done,
    output logic [rbcw_pkg::DIV_N-1:0]     quotient
);

    localparam int CNT_W = $clog2(rbcw_pkg::DIV_N + 1);

    logic [rbcw_pkg::DIV_D-1:0] rem_reg,  rem_next;
    logic [rbcw_pkg::DIV_N-1:0] quo_reg,  quo_next;
    logic [rbcw_pkg::DIV_D-1:0] dvs_reg;
    logic [CNT_W-1:0]           cnt_reg,  cnt_next;
    logic                       run_reg,  run_next;
    logic                       done_reg, done_next;
    logic [rbcw_pkg::DIV_D:0]   trial;

    // shift in one dividend bit, subtract when it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[rbcw_pkg::DIV_N-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = rbcw_pkg::DIV_D'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[rbcw_pkg::DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rbcw_pkg::DIV_D-1:0];
                quo_next = {quo_reg[rbcw_pkg::DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(rbcw_pkg::DIV_N - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/rbcw_core.sv */
// Sequencer and datapath registers of the cylinder warp: drives the shared
// multiplier through the sine/cosine series and the point math, and the
// divider for the inverse scale. Depends on rbcw_pkg, rbcw_mul and rbcw_div.
module rbcw_core #(
    parameter int DRAW_COUNT = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rbcw_pkg::in_t    item,
    input  rbcw_pkg::cfg_t   cfg,
    input  logic             scale_wr,
    output logic             busy,
    output logic             res_valid,
    input  logic             res_take,
    output rbcw_pkg::out_t   res
);

    localparam int SLOT_W = (DRAW_COUNT > 1) ? $clog2(DRAW_COUNT) : 1;
    localparam int SUM_W  = 16 + $clog2(DRAW_COUNT) + 1;

    // sequencer states
    localparam logic [5:0] ST_IDLE      = 6'd0;
    localparam logic [5:0] ST_INV_START = 6'd1;
    localparam logic [5:0] ST_INV_WAIT  = 6'd2;
    localparam logic [5:0] ST_J_PH      = 6'd3;
    localparam logic [5:0] ST_J_RET     = 6'd4;
    localparam logic [5:0] ST_RR        = 6'd5;
    localparam logic [5:0] ST_X_M1      = 6'd6;
    localparam logic [5:0] ST_X_V       = 6'd7;
    localparam logic [5:0] ST_X_M2      = 6'd8;
    localparam logic [5:0] ST_X_PH      = 6'd9;
    localparam logic [5:0] ST_X_RET     = 6'd10;
    localparam logic [5:0] ST_X_T       = 6'd11;
    localparam logic [5:0] ST_X_M3      = 6'd12;
    localparam logic [5:0] ST_X_OUT     = 6'd13;
    localparam logic [5:0] ST_Y_M       = 6'd14;
    localparam logic [5:0] ST_Y_OUT     = 6'd15;
    localparam logic [5:0] ST_Z_M1      = 6'd16;
    localparam logic [5:0] ST_Z_V       = 6'd17;
    localparam logic [5:0] ST_Z_M2      = 6'd18;
    localparam logic [5:0] ST_Z_PH      = 6'd19;
    localparam logic [5:0] ST_Z_RET     = 6'd20;
    localparam logic [5:0] ST_Z_OUT     = 6'd21;
    localparam logic [5:0] ST_A_M       = 6'd22;
    localparam logic [5:0] ST_A_PH      = 6'd23;
    localparam logic [5:0] ST_A_RET     = 6'd24;
    localparam logic [5:0] ST_P1        = 6'd25;
    localparam logic [5:0] ST_P2        = 6'd26;
    localparam logic [5:0] ST_C_M       = 6'd27;
    localparam logic [5:0] ST_C_OUT     = 6'd28;
    localparam logic [5:0] ST_DONE      = 6'd29;
    localparam logic [5:0] SC_F         = 6'd30;
    localparam logic [5:0] SC_TH        = 6'd31;
    localparam logic [5:0] SC_T2        = 6'd32;
    localparam logic [5:0] SC_M         = 6'd33;
    localparam logic [5:0] SC_D         = 6'd34;
    localparam logic [5:0] SC_W         = 6'd35;
    localparam logic [5:0] SC_S         = 6'd36;
    localparam logic [5:0] SC_S2        = 6'd37;
    localparam logic [5:0] SC_Q         = 6'd38;

    // last term index of each series
    localparam logic [3:0] SIN_LAST = 4'd4;
    localparam logic [3:0] COS_LAST = 4'd10;

    logic [5:0]               state_reg, ret_reg;
    rbcw_pkg::in_t            in_reg;
    logic [31:0]              ph_reg;
    logic [30:0]              th_reg;
    logic [31:0]              t2_reg;
    logic [30:0]              acc_reg, sres_reg;
    logic [3:0]               idx_reg;
    logic signed [31:0]       sn_reg, cs_reg, sr_reg, cr_reg, rr_reg;
    logic signed [33:0]       v_reg, t_reg;
    logic signed [31:0]       nx_reg, ny_reg, nz_reg, proj_reg, inv_reg;
    logic signed [rbcw_pkg::PROD_W-1:0] sum_reg;
    logic [15:0]              color_reg;
    logic                     dirty_reg;
    logic [15:0]              draws_reg [DRAW_COUNT];
    logic [SLOT_W-1:0]        slot_reg;

    logic signed [rbcw_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [rbcw_pkg::PROD_W-1:0] p;
    logic                               div_start, div_done;
    logic [rbcw_pkg::DIV_N-1:0]         div_dividend, div_q;
    logic [rbcw_pkg::DIV_D-1:0]         div_divisor;
    logic [SUM_W-1:0]                   draw_sum;
    logic signed [rbcw_pkg::MUL_W-1:0]  draw_diff;
    logic [31:0]                        scale_mag;
    logic signed [rbcw_pkg::PROD_W-1:0] w_val, w_abs;
    logic [31:0]                        series_q;

    rbcw_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (p)
    );

    rbcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // sum of the stored draws minus 2.0
    always_comb
    begin
        draw_sum = '0;
        for (int i = 0; i < DRAW_COUNT; i++)
            draw_sum = draw_sum + SUM_W'(draws_reg[i]);
        draw_diff = $signed({{(rbcw_pkg::MUL_W-SUM_W){1'b0}}, draw_sum}) - 34'sd131072;
    end

    assign scale_mag = cfg.scale[31] ? 32'(-cfg.scale) : cfg.scale;

    // series term quotient from the reciprocal product
    assign series_q = 32'(p >> rbcw_pkg::series_shift(idx_reg));

    // color word and its magnitude
    always_comb
    begin
        w_val = rbcw_pkg::rshr16(p) + 68'sd65536;
        w_abs = (w_val < 0) ? -w_val : w_val;
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_J_RET: begin mul_a = 34'(cfg.blur);   mul_b = draw_diff; end
            ST_X_M1:  begin mul_a = 34'(rr_reg);     mul_b = 34'(sr_reg); end
            ST_X_M2,
            ST_Z_M2:  begin mul_a = v_reg;           mul_b = rbcw_pkg::TURN_PER_RAD; end
            ST_X_RET: begin mul_a = 34'(cfg.amount); mul_b = 34'(sn_reg); end
            ST_X_M3:  begin mul_a = t_reg;           mul_b = 34'(cfg.x_gain); end
            ST_Y_M:   begin mul_a = 34'(in_reg.affine_y); mul_b = 34'(cfg.y_gain); end
            ST_Z_M1:  begin mul_a = 34'(rr_reg);     mul_b = 34'(cr_reg); end
            ST_Z_RET: begin mul_a = 34'(cfg.amount); mul_b = 34'(cs_reg); end
            ST_A_M:   begin mul_a = 34'(cfg.angle);  mul_b = rbcw_pkg::TURN_PER_RAD; end
            ST_A_RET: begin mul_a = 34'(cs_reg);     mul_b = 34'(nx_reg); end
            ST_P1:    begin mul_a = 34'(sn_reg);     mul_b = 34'(ny_reg); end
            ST_C_M:   begin mul_a = 34'(inv_reg);    mul_b = 34'(proj_reg); end
            SC_F:     begin mul_a = $signed({4'b0, ph_reg[29:0]});
                            mul_b = rbcw_pkg::HALF_PI_Q30; end
            SC_TH:    begin mul_a = $signed({3'b0, p[60:30]});
                            mul_b = $signed({3'b0, p[60:30]}); end
            SC_M:     begin mul_a = $signed({2'b0, t2_reg});
                            mul_b = $signed({3'b0, acc_reg}); end
            SC_D:     begin mul_a = $signed({2'b0, p[61:30]});
                            mul_b = rbcw_pkg::series_recip(idx_reg); end
            SC_S:     begin mul_a = $signed({3'b0, th_reg});
                            mul_b = $signed({3'b0, acc_reg}); end
            default:  begin mul_a = '0;              mul_b = '0; end
        endcase
    end

    // divider request
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        if (state_reg == ST_INV_START && cfg.scale != '0)
        begin
            div_start    = 1'b1;
            div_dividend = 34'h1_0000_0000 + {3'b0, scale_mag[31:1]};
            div_divisor  = scale_mag;
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            dirty_reg <= 1'b0;
            inv_reg   <= rbcw_pkg::INV_RESET;
            slot_reg  <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < DRAW_COUNT; i++)
                draws_reg[i] <= rbcw_pkg::DRAW_RESET;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        in_reg    <= item;
                        state_reg <= dirty_reg ? ST_INV_START : ST_J_PH;
                    end
                end
                ST_INV_START:
                begin
                    if (cfg.scale == '0)
                    begin
                        inv_reg   <= rbcw_pkg::Q16_MAX;
                        if (!scale_wr)
                            dirty_reg <= 1'b0;
                        state_reg <= ST_J_PH;
                    end
                    else
                        state_reg <= ST_INV_WAIT;
                end
                ST_INV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (cfg.scale[31])
                            inv_reg <= (div_q > 34'h0_8000_0000) ? rbcw_pkg::Q16_MIN
                                                                  : 32'(-div_q);
                        else
                            inv_reg <= (div_q > 34'h0_7FFF_FFFF) ? rbcw_pkg::Q16_MAX
                                                                  : div_q[31:0];
                        if (!scale_wr)
                            dirty_reg <= 1'b0;
                        state_reg <= ST_J_PH;
                    end
                end
                ST_J_PH:
                begin
                    ph_reg    <= {in_reg.random_angle, 16'b0};
                    ret_reg   <= ST_J_RET;
                    state_reg <= SC_F;
                end
                ST_J_RET:
                begin
                    sr_reg    <= sn_reg;
                    cr_reg    <= cs_reg;
                    state_reg <= ST_RR;
                end
                ST_RR:
                begin
                    rr_reg <= rbcw_pkg::sat32(rbcw_pkg::rshr16(p));
                    draws_reg[slot_reg] <= in_reg.random_refill;
                    slot_reg  <= (slot_reg == SLOT_W'(DRAW_COUNT - 1)) ? '0
                                                                       : slot_reg + 1'b1;
                    state_reg <= ST_X_M1;
                end
                ST_X_M1:  state_reg <= ST_X_V;
                ST_X_V:
                begin
                    v_reg     <= 34'(in_reg.affine_x) + 34'(rbcw_pkg::rshr30(p));
                    state_reg <= ST_X_M2;
                end
                ST_X_M2:  state_reg <= ST_X_PH;
                ST_X_PH:
                begin
                    ph_reg    <= p[47:16];
                    ret_reg   <= ST_X_RET;
                    state_reg <= SC_F;
                end
                ST_X_RET: state_reg <= ST_X_T;
                ST_X_T:
                begin
                    t_reg     <= 34'(rbcw_pkg::rshr30(p));
                    state_reg <= ST_X_M3;
                end
                ST_X_M3:  state_reg <= ST_X_OUT;
                ST_X_OUT:
                begin
                    nx_reg    <= rbcw_pkg::sat32(68'(in_reg.accum_x) + rbcw_pkg::rshr16(p));
                    state_reg <= ST_Y_M;
                end
                ST_Y_M:   state_reg <= ST_Y_OUT;
                ST_Y_OUT:
                begin
                    ny_reg    <= rbcw_pkg::sat32(68'(in_reg.accum_y) + 68'(rr_reg)
                                                 + rbcw_pkg::rshr16(p));
                    state_reg <= ST_Z_M1;
                end
                ST_Z_M1:  state_reg <= ST_Z_V;
                ST_Z_V:
                begin
                    v_reg     <= 34'(in_reg.affine_x) + 34'(rbcw_pkg::rshr30(p));
                    state_reg <= ST_Z_M2;
                end
                ST_Z_M2:  state_reg <= ST_Z_PH;
                ST_Z_PH:
                begin
                    ph_reg    <= p[47:16];
                    ret_reg   <= ST_Z_RET;
                    state_reg <= SC_F;
                end
                ST_Z_RET: state_reg <= ST_Z_OUT;
                ST_Z_OUT:
                begin
                    nz_reg    <= rbcw_pkg::sat32(68'(in_reg.accum_z) + rbcw_pkg::rshr30(p));
                    state_reg <= ST_A_M;
                end
                ST_A_M:   state_reg <= ST_A_PH;
                ST_A_PH:
                begin
                    ph_reg    <= p[47:16];
                    ret_reg   <= ST_A_RET;
                    state_reg <= SC_F;
                end
                ST_A_RET: state_reg <= ST_P1;
                ST_P1:
                begin
                    sum_reg   <= p;
                    state_reg <= ST_P2;
                end
                ST_P2:
                begin
                    proj_reg  <= rbcw_pkg::sat32(rbcw_pkg::rshr30(sum_reg + p)
                                                 + 68'(cfg.offset));
                    state_reg <= ST_C_M;
                end
                ST_C_M:   state_reg <= ST_C_OUT;
                ST_C_OUT:
                begin
                    color_reg <= w_abs[16:1];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_take)
                        state_reg <= ST_IDLE;
                end
                // sine/cosine subroutine on ph_reg
                SC_F:     state_reg <= SC_TH;
                SC_TH:
                begin
                    th_reg    <= p[60:30];
                    state_reg <= SC_T2;
                end
                SC_T2:
                begin
                    t2_reg    <= p[61:30];
                    acc_reg   <= rbcw_pkg::ONE_Q30;
                    idx_reg   <= '0;
                    state_reg <= SC_M;
                end
                SC_M:     state_reg <= SC_D;
                SC_D:     state_reg <= SC_W;
                SC_W:
                begin
                    acc_reg <= (series_q > 32'(rbcw_pkg::ONE_Q30)) ? '0
                               : rbcw_pkg::ONE_Q30 - series_q[30:0];
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SIN_LAST)
                        state_reg <= SC_S;
                    else if (idx_reg == COS_LAST)
                        state_reg <= SC_Q;
                    else
                        state_reg <= SC_M;
                end
                SC_S:     state_reg <= SC_S2;
                SC_S2:
                begin
                    sres_reg  <= (p[61:30] > 32'(rbcw_pkg::ONE_Q30)) ? rbcw_pkg::ONE_Q30
                                                                       : p[60:30];
                    acc_reg   <= rbcw_pkg::ONE_Q30;
                    state_reg <= SC_M;
                end
                SC_Q:
                begin
                    // quadrant fixes signs and swaps
                    unique case (ph_reg[31:30])
                        2'd0:
                        begin
                            sn_reg <= $signed({1'b0, sres_reg});
                            cs_reg <= $signed({1'b0, acc_reg});
                        end
                        2'd1:
                        begin
                            sn_reg <= $signed({1'b0, acc_reg});
                            cs_reg <= -$signed({1'b0, sres_reg});
                        end
                        2'd2:
                        begin
                            sn_reg <= -$signed({1'b0, sres_reg});
                            cs_reg <= -$signed({1'b0, acc_reg});
                        end
                        default:
                        begin
                            sn_reg <= -$signed({1'b0, acc_reg});
                            cs_reg <= $signed({1'b0, sres_reg});
                        end
                    endcase
                    state_reg <= ret_reg;
                end
                default:  state_reg <= ST_IDLE;
            endcase
            if (scale_wr)
                dirty_reg <= 1'b1;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.out_x = nx_reg;
    assign res.out_y = ny_reg;
    assign res.out_z = nz_reg;
    assign res.color = color_reg;

`ifndef NO_ASSERTIONS
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == SC_W || state_reg == ST_INV_WAIT))
        else $error("divider finished outside a wait state");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("request started while busy");

    a_take_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_take) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after result");

    a_slot_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RR |=> slot_reg != $past(slot_reg))
        else $error("draw slot did not advance");
`endif

endmodule
